// ----- design/swz_pkg.sv -----
// Shared types and constants for the sliding-window z-score detector.
package swz_pkg;

  localparam int WINDOW_DEPTH_DEF = 512;
  localparam int SAMPLE_W         = 16;
  localparam int NUM_CH           = 3;

  localparam logic [7:0] THR_RESET    = 8'd9;
  localparam logic [1:0] REG_THR_ADDR = 2'd0;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_CHK_SQ,
    ST_CHK_PROD,
    ST_CHK_CMP
  } state_t;

  // strobes for the check pipeline of each lane
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } chk_ctrl_t;

  // window statistics update
  typedef struct packed {
    logic upd;
    logic full;
  } stat_ctrl_t;

endpackage

// ----- design/swz_ram.sv -----
// Generic single-port-write, registered-read RAM.
module swz_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- design/swz_stats.sv -----
// Running sum and sum of squares of one channel's window.
module swz_stats #(
  parameter int WINDOW_DEPTH = swz_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  swz_pkg::stat_ctrl_t                              ctrl,
  input  logic signed [swz_pkg::SAMPLE_W-1:0]              x,
  input  logic signed [swz_pkg::SAMPLE_W-1:0]              old,
  output logic signed [swz_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] s_r,
  output logic [31+$clog2(WINDOW_DEPTH)-1:0]               q_r
);

  localparam int LOG_W = $clog2(WINDOW_DEPTH);
  localparam int S_W   = swz_pkg::SAMPLE_W + LOG_W;
  localparam int Q_W   = 31 + LOG_W;

  logic signed [31:0]   xsq;
  logic signed [31:0]   oldsq;
  logic signed [S_W-1:0] s_nxt;
  logic [Q_W-1:0]        q_nxt;

  assign xsq   = 32'(x) * 32'(x);
  assign oldsq = 32'(old) * 32'(old);

  // leaving sample only counts once the window has wrapped
  always_comb begin
    s_nxt = s_r + S_W'(x);
    q_nxt = q_r + Q_W'(xsq[30:0]);
    if (ctrl.full) begin
      s_nxt = s_nxt - S_W'(old);
      q_nxt = q_nxt - Q_W'(oldsq[30:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
      q_r <= '0;
    end else if (ctrl.upd) begin
      s_r <= s_nxt;
      q_r <= q_nxt;
    end
  end

endmodule

// ----- design/swz_chk_lane.sv -----
// Three-stage integer z-score test for one channel.
module swz_chk_lane #(
  parameter int WINDOW_DEPTH = swz_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                             clk,
  input  swz_pkg::chk_ctrl_t                               ctrl,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]                n,
  input  logic [7:0]                                       thr,
  input  logic signed [swz_pkg::SAMPLE_W-1:0]              x,
  input  logic signed [swz_pkg::SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] s,
  input  logic [31+$clog2(WINDOW_DEPTH)-1:0]               q,
  output logic                                             flag
);

  localparam int LOG_W  = $clog2(WINDOW_DEPTH);
  localparam int N_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int S_W    = swz_pkg::SAMPLE_W + LOG_W;
  localparam int Q_W    = 31 + LOG_W;
  localparam int NQ_W   = N_W + Q_W;
  localparam int SS_W   = 2 * S_W;
  localparam int DEV_W  = N_W + swz_pkg::SAMPLE_W + 1;
  localparam int DEV2_W = 2 * DEV_W - 1;
  localparam int TN_W   = 8 + N_W;
  localparam int L_W    = N_W + DEV2_W;
  localparam int R_W    = TN_W + NQ_W;
  localparam int C_W    = (L_W > R_W) ? L_W : R_W;

  // stage 1: n*Q, S^2, n*x - S, thr*n
  logic [NQ_W-1:0]         nq_r, nq_nxt;
  logic signed [SS_W-1:0]  ss_s;
  logic [SS_W-1:0]         ss_r;
  logic signed [DEV_W-1:0] dev_r, dev_nxt;
  logic [TN_W-1:0]         tn_r, tn_nxt;
  logic [N_W-1:0]          n_r;
  logic                    ngt1_r;
  // stage 2: D = nQ - S^2, dev^2
  logic signed [NQ_W:0]    diff;
  logic [NQ_W-1:0]         d_r;
  logic                    pos_r;
  logic signed [2*DEV_W-1:0] dev2_s;
  logic [DEV2_W-1:0]       dev2_r;
  // stage 3: both sides of the test
  logic [L_W-1:0]          lhs_r, lhs_nxt;
  logic [R_W-1:0]          rhs_r, rhs_nxt;

  assign nq_nxt  = NQ_W'(n) * NQ_W'(q);
  assign ss_s    = SS_W'(s) * SS_W'(s);
  assign dev_nxt = DEV_W'($signed({1'b0, n})) * DEV_W'(x) - DEV_W'(s);
  assign tn_nxt  = TN_W'(thr) * TN_W'(n);

  assign diff   = $signed({1'b0, nq_r}) - $signed({1'b0, NQ_W'(ss_r)});
  assign dev2_s = (2 * DEV_W)'(dev_r) * (2 * DEV_W)'(dev_r);

  assign lhs_nxt = L_W'(n_r - N_W'(1)) * L_W'(dev2_r);
  assign rhs_nxt = R_W'(tn_r) * R_W'(d_r);

  assign flag = ngt1_r && pos_r && (C_W'(lhs_r) > C_W'(rhs_r));

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      nq_r   <= nq_nxt;
      ss_r   <= $unsigned(ss_s);
      dev_r  <= dev_nxt;
      tn_r   <= tn_nxt;
      n_r    <= n;
      ngt1_r <= (n > N_W'(1));
    end
    if (ctrl.ld2) begin
      d_r    <= diff[NQ_W-1:0];
      pos_r  <= !diff[NQ_W] && (diff != '0);
      dev2_r <= dev2_s[DEV2_W-1:0];
    end
    if (ctrl.ld3) begin
      lhs_r <= lhs_nxt;
      rhs_r <= rhs_nxt;
    end
  end

endmodule

// ----- design/sliding_window_zscore_anomaly.sv -----
// Top level: three-channel sliding-window z-score anomaly detector, three-sigma at reset.
// Push: window RAM read at acceptance, update and write-back next cycle; input waits until done.
// Check: result registered after the three-stage multiply chain of each lane, once the
//   result register is free. Result held until taken; input waits if full.
// Reset (rst_n, synchronous, active low): pointer, fill count, sums zeroed, threshold 9.
// Window RAM is not cleared; entries only count once the window is full.
module sliding_window_zscore_anomaly #(
  parameter int WINDOW_DEPTH = swz_pkg::WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // rate_sample[15:0], sync_sample[31:16], weight_sample[47:32]
  input  logic        in_tuser,   // cmd
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // rate_flag[0], sync_flag[1], weight_flag[2],
                                  // flag_count[4:3], zero pad[7:5]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int LOG_W = $clog2(WINDOW_DEPTH);
  localparam int N_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SW    = swz_pkg::SAMPLE_W;
  localparam int S_W   = SW + LOG_W;
  localparam int Q_W   = 31 + LOG_W;
  localparam int ROW_W = swz_pkg::NUM_CH * SW;

  swz_pkg::state_t     state_r, state_nxt;
  swz_pkg::chk_ctrl_t  chk_ctrl;
  swz_pkg::stat_ctrl_t stat_ctrl;

  logic [LOG_W-1:0] wp_r, wp_nxt;
  logic [N_W-1:0]   fill_r, fill_nxt;
  logic [7:0]       thr_r;
  logic [ROW_W-1:0] sample_r;
  logic [ROW_W-1:0] old_row;
  logic             in_acc;
  logic             ram_re;
  logic             out_load;
  logic             out_valid_r;
  logic [4:0]       out_data_r;
  logic [2:0]       flag_w;
  logic [1:0]       count_w;
  logic             cfg_wr;

  logic signed [S_W-1:0] s_w [swz_pkg::NUM_CH];
  logic [Q_W-1:0]        q_w [swz_pkg::NUM_CH];

  assign in_acc = in_tvalid && in_tready;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == swz_pkg::REG_THR_ADDR) ? 32'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= swz_pkg::THR_RESET;
    end else if (cfg_wr && (cfg_paddr == swz_pkg::REG_THR_ADDR)) begin
      thr_r <= cfg_pwdata[7:0];
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swz_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == swz_pkg::CMD_CHECK) ? swz_pkg::ST_CHK_SQ : swz_pkg::ST_PUSH;
        end
      end
      swz_pkg::ST_PUSH:     state_nxt = swz_pkg::ST_IDLE;
      swz_pkg::ST_CHK_SQ:   state_nxt = swz_pkg::ST_CHK_PROD;
      swz_pkg::ST_CHK_PROD: state_nxt = swz_pkg::ST_CHK_CMP;
      swz_pkg::ST_CHK_CMP: begin
        if (out_load) begin
          state_nxt = swz_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swz_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = (state_r == swz_pkg::ST_IDLE);
    ram_re         = in_acc && (in_tuser == swz_pkg::CMD_PUSH);
    stat_ctrl.upd  = (state_r == swz_pkg::ST_PUSH);
    stat_ctrl.full = (fill_r == N_W'(WINDOW_DEPTH));
    chk_ctrl.ld1   = in_acc && (in_tuser == swz_pkg::CMD_CHECK);
    chk_ctrl.ld2   = (state_r == swz_pkg::ST_CHK_SQ);
    chk_ctrl.ld3   = (state_r == swz_pkg::ST_CHK_PROD);
    // result register frees up in the same cycle it is taken
    out_load       = (state_r == swz_pkg::ST_CHK_CMP) && (!out_valid_r || out_tready);
  end

  // pointer wraps at the window depth, fill saturates there
  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (stat_ctrl.upd) begin
      wp_nxt = (wp_r == LOG_W'(WINDOW_DEPTH - 1)) ? '0 : wp_r + LOG_W'(1);
      if (!stat_ctrl.full) begin
        fill_nxt = fill_r + N_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swz_pkg::ST_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // push samples held for the write-back cycle
  always_ff @(posedge clk) begin
    if (ram_re) begin
      sample_r <= in_tdata;
    end
  end

  // ---------------- window memory ----------------
  // one row holds all three channels at the shared pointer
  swz_ram #(
    .WIDTH (ROW_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_win_ram (
    .clk     (clk),
    .we      (stat_ctrl.upd),
    .waddr   (wp_r),
    .wdata   (sample_r),
    .re      (ram_re),
    .raddr   (wp_r),
    .rdata_r (old_row)
  );

  // ---------------- per-channel statistics and test ----------------
  for (genvar ch = 0; ch < swz_pkg::NUM_CH; ch++) begin : g_ch
    swz_stats #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_stats (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (stat_ctrl),
      .x     ($signed(sample_r[ch*SW +: SW])),
      .old   ($signed(old_row[ch*SW +: SW])),
      .s_r   (s_w[ch]),
      .q_r   (q_w[ch])
    );

    swz_chk_lane #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_lane (
      .clk  (clk),
      .ctrl (chk_ctrl),
      .n    (fill_r),
      .thr  (thr_r),
      .x    ($signed(in_tdata[ch*SW +: SW])),
      .s    (s_w[ch]),
      .q    (q_w[ch]),
      .flag (flag_w[ch])
    );
  end

  assign count_w = 2'(flag_w[0]) + 2'(flag_w[1]) + 2'(flag_w[2]);

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {count_w, flag_w};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};

  // ---------------- checks ----------------
  a_result_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == swz_pkg::ST_CHK_CMP))
    else $error("result raised outside compare state");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == swz_pkg::CMD_PUSH) && !stat_ctrl.full)
      |-> ##2 (fill_r == $past(fill_r, 2) + N_W'(1)))
    else $error("fill count did not advance on push");

  a_short_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == swz_pkg::ST_CHK_CMP) && (fill_r <= N_W'(1))) |-> (flag_w == 3'b000))
    else $error("flag set with fewer than two samples");

endmodule

// ----- bench/sliding_window_zscore_anomaly_tb.sv -----
// Self-checking bench for the three-channel sliding-window z-score detector.
`timescale 1ns / 1ps

module sliding_window_zscore_anomaly_tb;

  localparam int WIN = swz_pkg::WINDOW_DEPTH_DEF;

  typedef longint unsigned u64_t;
  typedef logic [127:0]    u128_t;

  // one expected result transfer
  typedef struct packed {
    logic       rate;
    logic       sync;
    logic       weight;
    logic [1:0] count;
  } flags_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;    // rate[15:0], sync[31:16], weight[47:32]
  logic        in_tuser = 1'b0;  // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // rate_flag[0], sync_flag[1], weight_flag[2], count[4:3]

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sliding_window_zscore_anomaly #(.WINDOW_DEPTH(WIN)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the detector state, advanced on every accepted input transfer
  // ---------------------------------------------------------------------------
  logic signed [15:0] win_mem [3][WIN];   // entries read only once the window is full
  int unsigned        wr_ptr;
  int unsigned        fill;
  longint             sum_acc [3];
  u64_t               sq_acc  [3];
  logic [7:0]         thr_sq;

  flags_t pending_flags [$];  // expected results, oldest first
  int     errors;

  // traffic shaping, read by the driver and by the receiver process
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_left;              // receiver hold-off, counted down once per cycle

  // per-phase centre and spread of each channel's samples
  int level  [3];
  int spread [3];

  function automatic void check_field(string name, int expd, int act);
    if (expd != act) begin
      $error("%s mismatch: expected %0d, got %0d", name, expd, act);
      errors++;
    end
  endfunction

  // Exact integer form of |x - mean| / std > sqrt(thr), sample deviation (n-1).
  // The right-hand side can pass 64 bits, so both sides are compared at 128.
  function automatic logic zscore_exceeds(int ch, logic signed [15:0] x);
    u64_t   n, s_abs, nq, ss, d, dev_abs;
    longint s, dev;
    u128_t  lhs, rhs;
    n     = fill;
    s     = sum_acc[ch];
    s_abs = (s < 0) ? u64_t'(-s) : u64_t'(s);
    nq    = n * sq_acc[ch];
    ss    = s_abs * s_abs;
    // too few samples, or a constant window: never flagged
    if (n <= 1 || nq <= ss) return 1'b0;
    d       = nq - ss;
    dev     = longint'(n) * longint'(x) - s;
    dev_abs = (dev < 0) ? u64_t'(-dev) : u64_t'(dev);
    lhs = u128_t'(n - 1) * u128_t'(dev_abs * dev_abs);
    rhs = u128_t'(thr_sq) * u128_t'(n) * u128_t'(d);
    return lhs > rhs;
  endfunction

  task automatic predict_transfer(input logic cmd, input logic [47:0] data);
    logic signed [15:0] x [3];
    longint             old;
    flags_t             f;
    x[0] = data[15:0];
    x[1] = data[31:16];
    x[2] = data[47:32];
    if (cmd == swz_pkg::CMD_PUSH) begin
      for (int ch = 0; ch < 3; ch++) begin
        // once full, the overwritten sample leaves both running sums
        if (fill >= WIN) begin
          old = longint'(win_mem[ch][wr_ptr]);
          sum_acc[ch] -= old;
          sq_acc[ch]  -= u64_t'(old * old);
        end
        win_mem[ch][wr_ptr] = x[ch];
        sum_acc[ch] += longint'(x[ch]);
        sq_acc[ch]  += u64_t'(longint'(x[ch]) * longint'(x[ch]));
      end
      wr_ptr = (wr_ptr + 1) % WIN;
      if (fill < WIN) fill++;
    end else begin
      f.rate   = zscore_exceeds(0, x[0]);
      f.sync   = zscore_exceeds(1, x[1]);
      f.weight = zscore_exceeds(2, x[2]);
      f.count  = 2'(f.rate) + 2'(f.sync) + 2'(f.weight);
      pending_flags.push_back(f);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: changes at the falling edge, transfer seen at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic cmd, input logic [15:0] rate, sync, weight);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {weight, sync, rate};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_transfer(cmd, {weight, sync, rate});
  endtask

  // Drop valid, let every expected result arrive, then cover push latency.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write then read-back of the threshold register; block must be idle.
  task automatic cfg_write(input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= swz_pkg::REG_THR_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    thr_sq = value[7:0];  // only the low byte is kept
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    check_field("z_threshold_squared", {24'd0, thr_sq}, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when hold_left is loaded
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    flags_t f;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_flags.size() == 0) begin
        $error("result transfer with no expectation waiting: tdata %h", out_tdata);
        errors++;
      end else begin
        f = pending_flags.pop_front();
        check_field("rate_flag",   f.rate,   out_tdata[0]);
        check_field("sync_flag",   f.sync,   out_tdata[1]);
        check_field("weight_flag", f.weight, out_tdata[2]);
        check_field("flag_count",  f.count,  out_tdata[4:3]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample generation for the random traffic
  // ---------------------------------------------------------------------------
  task automatic pick_channel_levels();
    for (int ch = 0; ch < 3; ch++) begin
      level[ch]  = int'($urandom_range(16000)) - 8000;
      spread[ch] = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(600, 1));
    end
  endtask

  // Mostly near the channel level; checks get frequent outliers so flags fire,
  // and a share of full-range values toggles every bit.
  function automatic logic [15:0] draw_sample(int ch, bit for_check);
    int r, v;
    r = $urandom_range(99);
    if (r < 8) return 16'($urandom);
    if (for_check && r < 40)
      v = level[ch] + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(30000, 2000));
    else
      v = level[ch] + int'($urandom_range(2 * spread[ch])) - spread[ch];
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty window, single sample, constant window, full-scale samples.
  task automatic test_reset_corners();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_item(swz_pkg::CMD_CHECK, 16'h8000, 16'h7FFF, 16'h0000);  // n = 0
    send_item(swz_pkg::CMD_PUSH,  16'h7FFF, 16'h8000, 16'h0001);
    send_item(swz_pkg::CMD_CHECK, 16'h8000, 16'h7FFF, 16'h0001);  // n = 1
    send_item(swz_pkg::CMD_PUSH,  16'h7FFF, 16'h8000, 16'h0001);
    send_item(swz_pkg::CMD_CHECK, 16'h8000, 16'h7FFF, 16'hFFFF);  // zero deviation
    send_item(swz_pkg::CMD_PUSH,  16'h0000, 16'h0000, 16'h0000);
    send_item(swz_pkg::CMD_PUSH,  16'h0001, 16'hFFFF, 16'h0002);
    send_item(swz_pkg::CMD_PUSH,  16'hFFFF, 16'h0001, 16'hFFFE);
    send_item(swz_pkg::CMD_PUSH,  16'h0000, 16'h0000, 16'h0000);
    send_item(swz_pkg::CMD_CHECK, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_item(swz_pkg::CMD_CHECK, 16'h0000, 16'h0000, 16'h0000);
    send_item(swz_pkg::CMD_CHECK, 16'h8000, 16'h7FFF, 16'h8000);
    settle();
  endtask

  // Threshold of zero, discarded upper bits, and both ends of the range.
  task automatic test_threshold_register();
    cfg_write(32'd0);  // anything off the mean is flagged
    send_item(swz_pkg::CMD_CHECK, 16'h0000, 16'h0000, 16'h0000);
    send_item(swz_pkg::CMD_CHECK, 16'h0001, 16'h0002, 16'h0003);
    settle();
    cfg_write(32'hFFFF_FF05);
    send_item(swz_pkg::CMD_CHECK, 16'h7FFF, 16'h8000, 16'h7FFF);
    settle();
    cfg_write(32'd255);
    send_item(swz_pkg::CMD_CHECK, 16'h8000, 16'h7FFF, 16'h8000);
    send_item(swz_pkg::CMD_CHECK, 16'h0010, 16'hFFF0, 16'h0100);
    settle();
    cfg_write(32'd1);
    send_item(swz_pkg::CMD_CHECK, 16'h0004, 16'hFFFC, 16'h0100);
    send_item(swz_pkg::CMD_PUSH,  16'h0003, 16'hFFFD, 16'h0080);
    send_item(swz_pkg::CMD_CHECK, 16'h0002, 16'h0002, 16'h0002);
    settle();
  endtask

  // Mixed push/check traffic under one threshold and one idling pattern.
  task automatic test_random_traffic(input int items, input int push_pct,
                                     input int tx_pct, input int rx_pct,
                                     input logic [31:0] thr);
    logic cmd;
    bit   chk;
    cfg_write(thr);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    pick_channel_levels();
    for (int i = 0; i < items; i++) begin
      if (i % 60 == 59) pick_channel_levels();
      cmd = ($urandom_range(99) < push_pct) ? swz_pkg::CMD_PUSH : swz_pkg::CMD_CHECK;
      chk = (cmd == swz_pkg::CMD_CHECK);
      send_item(cmd, draw_sample(0, chk), draw_sample(1, chk), draw_sample(2, chk));
    end
    settle();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // transfers, so the held result backs up into the input.
  task automatic test_backpressure();
    logic cmd;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left    = 300;
    for (int i = 0; i < 24; i++) begin
      cmd = ($urandom_range(2) == 0) ? swz_pkg::CMD_PUSH : swz_pkg::CMD_CHECK;
      send_item(cmd, draw_sample(0, 1'b1), draw_sample(1, 1'b1), draw_sample(2, 1'b1));
    end
    settle();
  endtask

  initial begin
    errors    = 0;
    wr_ptr    = 0;
    fill      = 0;
    thr_sq    = swz_pkg::THR_RESET;
    hold_left = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (int ch = 0; ch < 3; ch++) begin
      sum_acc[ch] = 0;
      sq_acc[ch]  = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_corners();
    test_threshold_register();
    // windows fill past depth during the third phase and wrap afterwards
    test_random_traffic(300, 80, 0,  0,  32'd9);
    test_random_traffic(280, 70, 59, 0,  32'd1);
    test_random_traffic(280, 70, 0,  59, 32'd255);
    test_backpressure();
    test_random_traffic(250, 60, 23, 23, 32'($urandom_range(255, 1)));

    if (errors == 0 && pending_flags.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
